@@ hw/rtl/scld_pkg.sv @@
// Package for the serial command line decoder: event codes, command word
// tables and the small structs passed between the matcher and the top level.
// Depends on nothing.
package scld_pkg;

	localparam int LINE_CAPACITY = 96;
	localparam int WORD_COUNT    = 7;
	localparam int MAX_WORD_LEN  = 14;
	localparam int CODE_W        = 4;
	localparam int LEN_W         = 4;

	localparam logic [7:0] CHAR_CR = 8'd13;
	localparam logic [7:0] CHAR_LF = 8'd10;
	localparam logic [7:0] CHAR_NUL = 8'd0;

	localparam logic [CODE_W-1:0] CODE_VERSION   = 4'd0;
	localparam logic [CODE_W-1:0] CODE_LED_ON    = 4'd1;
	localparam logic [CODE_W-1:0] CODE_LED_OFF   = 4'd2;
	localparam logic [CODE_W-1:0] CODE_SENSOR_ID = 4'd3;
	localparam logic [CODE_W-1:0] CODE_TELEMETRY = 4'd4;
	localparam logic [CODE_W-1:0] CODE_DIAG_I2C  = 4'd5;
	localparam logic [CODE_W-1:0] CODE_RESET     = 4'd6;
	localparam logic [CODE_W-1:0] CODE_UNKNOWN   = 4'd7;
	localparam logic [CODE_W-1:0] CODE_OVERFLOW  = 4'd8;

	localparam logic [WORD_COUNT-1:0] ALL_ALIVE = '1;

	// Word texts are left aligned: character p sits in bits [111-8p -: 8].
	localparam logic [8*MAX_WORD_LEN-1:0] WORD_TEXT [WORD_COUNT] = '{
		{"version",        56'h0},
		{"led on",         64'h0},
		{"led off",        56'h0},
		{"sensor id",      40'h0},
		{"telemetry once"},
		{"diag i2c",       48'h0},
		{"reset",          72'h0}
	};

	localparam logic [LEN_W-1:0] WORD_LEN [WORD_COUNT] = '{
		4'd7, 4'd6, 4'd7, 4'd9, 4'd14, 4'd8, 4'd5
	};

	// Code each word reports when it is the match at line end.
	localparam logic [CODE_W-1:0] WORD_CODE [WORD_COUNT] = '{
		CODE_VERSION, CODE_LED_ON, CODE_LED_OFF, CODE_SENSOR_ID,
		CODE_TELEMETRY, CODE_DIAG_I2C, CODE_RESET
	};

	typedef struct packed {
		logic [WORD_COUNT-1:0] alive;
		logic                  zero_seen;
	} line_flags_t;

	typedef struct packed {
		logic              valid;
		logic [CODE_W-1:0] code;
	} result_t;

	// Character of word k at position pos; zero past the table width.
	function automatic logic [7:0] word_char(input int unsigned k,
			input logic [LEN_W-1:0] pos);
		logic [7:0] ch;
		ch = 8'd0;
		if (pos < LEN_W'(MAX_WORD_LEN)) begin
			ch = WORD_TEXT[k][8*(MAX_WORD_LEN-1-int'(pos)) +: 8];
		end
		return ch;
	endfunction

endpackage

@@ hw/rtl/scld_match.sv @@
// Incremental command matcher: next line state and optional event for one byte.
// Purely combinational. Depends on scld_pkg.
module scld_match #(
	parameter int LINE_CAPACITY = scld_pkg::LINE_CAPACITY,
	localparam int CNT_W = $clog2(LINE_CAPACITY)
) (
	input  logic [7:0]            rx_byte,
	input  logic [CNT_W-1:0]      count,
	input  scld_pkg::line_flags_t flags,
	output logic [CNT_W-1:0]      count_next,
	output scld_pkg::line_flags_t flags_next,
	output scld_pkg::result_t     result
);

	localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(LINE_CAPACITY - 1);

	logic                             is_eol;
	logic [scld_pkg::WORD_COUNT-1:0]  hit;
	logic [scld_pkg::WORD_COUNT-1:0]  keep;
	logic [scld_pkg::CODE_W-1:0]      match_code;

	assign is_eol = (rx_byte == scld_pkg::CHAR_CR) || (rx_byte == scld_pkg::CHAR_LF);

	// Per-word hit at line end and per-word survival of this byte.
	always_comb begin
		for (int k = 0; k < scld_pkg::WORD_COUNT; k++) begin
			hit[k] = flags.alive[k] &&
				(flags.zero_seen || (CNT_W'(scld_pkg::WORD_LEN[k]) == count));
			if (rx_byte == scld_pkg::CHAR_NUL) begin
				keep[k] = (CNT_W'(scld_pkg::WORD_LEN[k]) == count);
			end else begin
				keep[k] = (count < CNT_W'(scld_pkg::WORD_LEN[k])) &&
					(scld_pkg::word_char(k, count[scld_pkg::LEN_W-1:0]) == rx_byte);
			end
		end
	end

	// Lowest-numbered matching word wins.
	always_comb begin
		match_code = scld_pkg::CODE_UNKNOWN;
		for (int k = scld_pkg::WORD_COUNT - 1; k >= 0; k--) begin
			if (hit[k]) begin
				match_code = scld_pkg::WORD_CODE[k];
			end
		end
	end

	always_comb begin
		count_next   = count;
		flags_next   = flags;
		result.valid = 1'b0;
		result.code  = scld_pkg::CODE_UNKNOWN;
		if (is_eol) begin
			if (count != '0) begin
				result.valid         = 1'b1;
				result.code          = match_code;
				count_next           = '0;
				flags_next.alive     = scld_pkg::ALL_ALIVE;
				flags_next.zero_seen = 1'b0;
			end
		end else if (count >= COUNT_LIMIT) begin
			result.valid         = 1'b1;
			result.code          = scld_pkg::CODE_OVERFLOW;
			count_next           = '0;
			flags_next.alive     = scld_pkg::ALL_ALIVE;
			flags_next.zero_seen = 1'b0;
		end else begin
			if (!flags.zero_seen) begin
				flags_next.alive     = flags.alive & keep;
				flags_next.zero_seen = (rx_byte == scld_pkg::CHAR_NUL);
			end
			count_next = count + 1'b1;
		end
	end

endmodule

@@ hw/rtl/serial_command_line_decoder.sv @@
// Top level of the serial command line decoder: input register, line state,
// result register and handshakes. Depends on scld_pkg and scld_match.
//
//   Channel   Direction  Handshake            Payload
//   input     in         in_valid / in_stall  rx_byte[7:0]
//   output    out        out_valid / out_stall event_code[3:0]
//
// Each byte is registered in the input register and decoded from there into the
// line state and, at a line end or overflow, into the result register. One byte
// is taken every clock unless the input stalls; the throughput is set by the
// matcher update of the line state.
// arst_n clears the line state, the input register and the result register.
// A stalled result holds; the input stalls only while a byte waits in the
// input register and the result register is full and stalled.
module serial_command_line_decoder #(
	parameter int LINE_CAPACITY = scld_pkg::LINE_CAPACITY,
	localparam int CNT_W = $clog2(LINE_CAPACITY)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  rx_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [scld_pkg::CODE_W-1:0] event_code
);

	// Input register stage.
	logic       rx_valid_s1;
	logic [7:0] rx_byte_s1;

	// Line state, updated when the byte in the input register is decoded.
	logic [CNT_W-1:0]      count_q;
	scld_pkg::line_flags_t flags_q;

	logic [CNT_W-1:0]      count_next;
	scld_pkg::line_flags_t flags_next;
	scld_pkg::result_t     result;

	logic                        out_valid_q;
	logic [scld_pkg::CODE_W-1:0] event_code_q;

	logic out_free;
	logic advance;
	logic load_s1;

	// The result register can take a new value when empty or being read.
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = rx_valid_s1 && out_free;
	assign load_s1  = !rx_valid_s1 || advance;
	assign in_stall = !load_s1;

	scld_match #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_match (
		.rx_byte   (rx_byte_s1),
		.count     (count_q),
		.flags     (flags_q),
		.count_next(count_next),
		.flags_next(flags_next),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid_s1 <= 1'b0;
		end else if (load_s1) begin
			rx_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q           <= '0;
			flags_q.alive     <= scld_pkg::ALL_ALIVE;
			flags_q.zero_seen <= 1'b0;
		end else if (advance) begin
			count_q <= count_next;
			flags_q <= flags_next;
		end
	end

	// A decoded byte that yields no event still empties a read result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid && out_free) begin
			event_code_q <= result.code;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_code = event_code_q;

endmodule

@@ hw/rtl/scld_checker.sv @@
// Port-level checks for the serial command line decoder, bound to the top.
// Depends on scld_pkg and serial_command_line_decoder.
module scld_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [scld_pkg::CODE_W-1:0] event_code
);

	logic in_accept;
	assign in_accept = in_valid && !in_stall;

	// Only codes up to overflow are ever reported.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_code <= scld_pkg::CODE_OVERFLOW))
		else $error("event code out of range");

	// A stalled event stays on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(event_code)))
		else $error("stalled event changed");

	// The input only stalls behind a stalled, full output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_stall) |-> (out_valid && out_stall))
		else $error("input stalled without output back-pressure");

	// A taken byte is registered, then decoded from there into the result register.
	// A byte that had to wait sat behind an event that was already shown.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(in_accept, 2) && !$past(out_valid)) |-> !out_valid)
		else $error("event appeared without a pending byte");

endmodule

bind serial_command_line_decoder scld_checker u_scld_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.event_code(event_code)
);
